// ===== rtl/websocket_frame_deframer_top_assert.svh =====
// Assertion macros for the WebSocket frame deframer checker.
// Needs i_clk and i_rst_n in scope at the point of use.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Plain property, checked out of reset.
`define WSFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition and consequent in the same cycle.
`define WSFD_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies.
package wsfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] OPCODE_TEXT  = 4'h1;
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam logic [2:0] MIN_BYTES    = 3'd6;

    typedef enum logic [2:0] {
        PH_OP     = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_KEY    = 3'd4,
        PH_PAY    = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CLOSE = 3'd2,
        ST_TEXT  = 3'd3,
        ST_LEN64 = 3'd4,
        ST_TRUNC = 3'd5
    } t_status;

    // Results caused by one accepted byte: payload byte first, then status.
    typedef struct packed {
        logic       pay_v;
        logic [7:0] pay_byte;
        logic       st_v;
        t_status    st;
    } t_job;

endpackage

// ===== rtl/websocket_frame_deframer_top.sv =====
// WebSocket frame deframer, top level.
// Input channel: push/full, one buffer byte per transaction with an
// end-of-buffer flag. An input transaction completes on a clock edge with
// push high and full low.
// Result channel: empty/pop. While empty is low the oldest result is on
// o_out_byte/o_byte_valid/o_is_last/o_status; pop with empty low takes it.
// Each payload byte gives one unmasked byte result; the end-of-buffer byte
// adds one final status result (byte_valid 0, is_last 1).
// Throughput: one byte per cycle while full is low, limited by the single result
// register; a byte with two results holds the output for both in turn.
// A byte's results pass through the job queue and then the output register
// before they reach the ports.
// A job queue of QUEUE_DEPTH entries sits between parser and output, so
// input keeps flowing while the receiver stalls until that queue fills;
// then full rises and holds until pop frees space.
// Reset (synchronous, active low) empties the queue and output and puts the
// parser at the first header byte; no clearing pass is needed.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue, wsfd_back.
module websocket_frame_deframer_top #(
    parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_is_last,
    output logic [2:0] o_status
);
    wsfd_pkg::t_job job, head;
    logic           job_wr, q_rd, q_empty, q_full;

    assign full = q_full;

    wsfd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_q_full        (q_full),
        .o_job_wr        (job_wr),
        .o_job           (job)
    );

    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_wr),
        .i_wr_job (job),
        .i_rd     (q_rd),
        .o_head   (head),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    wsfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_head       (head),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_is_last    (o_is_last),
        .o_status     (o_status)
    );

endmodule

// ===== rtl/wsfd_queue.sv =====
// Short job queue between the header parser and the result serialiser.
// Depends on wsfd_pkg.
module wsfd_queue #(
    parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wsfd_pkg::t_job i_wr_job,
    input  logic           i_rd,
    output wsfd_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsfd_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_head  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

// ===== rtl/wsfd_front.sv =====
// Header parser: takes buffer bytes, tracks frame phase, unmasks payload
// and decides the end-of-buffer status. Depends on wsfd_pkg.
module wsfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_buffer,
    input  logic           i_q_full,
    output logic           o_job_wr,
    output wsfd_pkg::t_job o_job
);
    wsfd_pkg::t_phase  r_phase, n_phase;
    wsfd_pkg::t_status r_pend, n_pend;
    logic [2:0]        r_seen, n_seen;
    logic [3:0]        r_opcode, n_opcode;
    logic              r_mask, n_mask;
    logic [15:0]       r_len, n_len;
    logic [15:0]       r_idx, n_idx;
    logic [31:0]       r_key, n_key;

    logic        accept;
    logic [2:0]  seen_inc;
    logic [3:0]  opc;
    logic [6:0]  len7;
    logic [15:0] len_ext;
    logic [15:0] idx_inc;
    logic [7:0]  key_byte;
    logic        pay_v;
    wsfd_pkg::t_status st;

    assign accept   = i_push && !i_q_full;
    assign seen_inc = (r_seen < wsfd_pkg::MIN_BYTES) ? r_seen + 3'd1 : r_seen;
    assign opc      = i_data_byte[3:0];
    assign len7     = i_data_byte[6:0];
    assign len_ext  = {r_len[15:8], i_data_byte};
    assign idx_inc  = r_idx + 16'd1;
    assign key_byte = r_mask ? r_key[{r_idx[1:0], 3'b000} +: 8] : 8'h00;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            wsfd_pkg::PH_OP: begin
                n_phase = (opc == wsfd_pkg::OPCODE_TEXT) ? wsfd_pkg::PH_LEN
                                                         : wsfd_pkg::PH_DONE;
            end
            wsfd_pkg::PH_LEN: begin
                if (len7 == wsfd_pkg::LEN_EXT16) begin
                    n_phase = wsfd_pkg::PH_EXT_HI;
                end else if (len7 == wsfd_pkg::LEN_EXT64) begin
                    n_phase = wsfd_pkg::PH_DONE;
                end else if (i_data_byte[7]) begin
                    n_phase = wsfd_pkg::PH_KEY;
                end else begin
                    n_phase = (len7 == 7'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAY;
                end
            end
            wsfd_pkg::PH_EXT_HI: begin
                n_phase = wsfd_pkg::PH_EXT_LO;
            end
            wsfd_pkg::PH_EXT_LO: begin
                if (r_mask) begin
                    n_phase = wsfd_pkg::PH_KEY;
                end else begin
                    n_phase = (len_ext == 16'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAY;
                end
            end
            wsfd_pkg::PH_KEY: begin
                if (r_idx[1:0] == 2'd3) begin
                    n_phase = (r_len == 16'd0) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAY;
                end
            end
            wsfd_pkg::PH_PAY: begin
                if (idx_inc >= r_len) begin
                    n_phase = wsfd_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // datapath and job outputs
    always_comb begin
        n_pend   = r_pend;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_len    = r_len;
        n_idx    = r_idx;
        n_key    = r_key;
        pay_v    = 1'b0;
        unique case (r_phase)
            wsfd_pkg::PH_OP: begin
                n_opcode = opc;
                if (opc == wsfd_pkg::OPCODE_CLOSE) begin
                    n_pend = wsfd_pkg::ST_CLOSE;
                end else if (opc != wsfd_pkg::OPCODE_TEXT) begin
                    n_pend = wsfd_pkg::ST_TEXT;
                end
            end
            wsfd_pkg::PH_LEN: begin
                n_mask = i_data_byte[7];
                n_len  = {9'd0, len7};
                n_idx  = 16'd0;
                if (len7 == wsfd_pkg::LEN_EXT64) begin
                    n_pend = wsfd_pkg::ST_LEN64;
                end
            end
            wsfd_pkg::PH_EXT_HI: begin
                n_len = {i_data_byte, 8'd0};
            end
            wsfd_pkg::PH_EXT_LO: begin
                n_len = len_ext;
                n_idx = 16'd0;
            end
            wsfd_pkg::PH_KEY: begin
                n_key[{r_idx[1:0], 3'b000} +: 8] = i_data_byte;
                n_idx = (r_idx[1:0] == 2'd3) ? 16'd0 : idx_inc;
            end
            wsfd_pkg::PH_PAY: begin
                pay_v = 1'b1;
                n_idx = idx_inc;
            end
            default: begin
                pay_v = 1'b0;
            end
        endcase

        // status order: short buffer, header error, unfinished frame
        if (seen_inc < wsfd_pkg::MIN_BYTES) begin
            st = wsfd_pkg::ST_SHORT;
        end else if (n_pend != wsfd_pkg::ST_OK) begin
            st = n_pend;
        end else if (3'(n_phase) < 3'(wsfd_pkg::PH_DONE)) begin
            st = wsfd_pkg::ST_TRUNC;
        end else begin
            st = wsfd_pkg::ST_OK;
        end

        o_job.pay_v    = pay_v;
        o_job.pay_byte = i_data_byte ^ key_byte;
        o_job.st_v     = i_end_of_buffer;
        o_job.st       = st;
        o_job_wr       = accept && (pay_v || i_end_of_buffer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_buffer)) begin
            r_phase  <= wsfd_pkg::PH_OP;
            r_pend   <= wsfd_pkg::ST_OK;
            r_seen   <= '0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_len    <= '0;
            r_idx    <= '0;
            r_key    <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_seen   <= seen_inc;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_key    <= n_key;
        end
    end

endmodule

// ===== rtl/wsfd_back.sv =====
// Result serialiser: splits queued jobs into single results and holds the
// oldest one in the output register. Depends on wsfd_pkg.
module wsfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  wsfd_pkg::t_job i_head,
    output logic           o_q_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_byte_valid,
    output logic           o_is_last,
    output logic [2:0]     o_status
);
    logic              r_out_v;
    logic              r_half;
    logic [7:0]        r_byte;
    logic              r_bv;
    logic              r_last;
    wsfd_pkg::t_status r_st;

    logic load, take, send_pay, split;

    assign load     = !r_out_v || i_pop;
    assign take     = load && !i_q_empty;
    assign send_pay = i_head.pay_v && !r_half;
    // payload byte goes first; the job stays queued until its status is out
    assign split    = send_pay && i_head.st_v;
    assign o_q_rd   = take && !split;

    assign o_empty      = !r_out_v;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bv;
    assign o_is_last    = r_last;
    assign o_status     = 3'(r_st);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_half  <= 1'b0;
        end else if (take) begin
            r_out_v <= 1'b1;
            r_half  <= split;
        end else if (i_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= send_pay ? i_head.pay_byte : 8'h00;
            r_bv   <= send_pay;
            r_last <= !send_pay;
            r_st   <= send_pay ? wsfd_pkg::ST_OK : i_head.st;
        end
    end

endmodule

// ===== rtl/wsfd_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on websocket_frame_deframer_top_assert.svh.
`include "websocket_frame_deframer_top_assert.svh"

module wsfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_buffer,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_is_last,
    input logic [2:0] o_status
);

    `WSFD_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_byte_valid) && $stable(o_is_last) && $stable(o_status)), "stalled result changed")

    `WSFD_ASSERT_IMPL(a_byte_fmt, !empty && o_byte_valid, !o_is_last && o_status == 3'd0, "payload result carries status")

    `WSFD_ASSERT_IMPL(a_stat_fmt, !empty && !o_byte_valid, o_is_last && o_out_byte == 8'h00 && o_status <= 3'd5, "bad status result")

    `WSFD_ASSERT_IMPL(a_full_out, full, !empty, "queue full with output register empty")

endmodule

bind websocket_frame_deframer_top wsfd_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for websocket_frame_deframer_top: random and directed receive buffers,
// checked against an in-bench frame parser. Needs wsfd_pkg and the deframer RTL.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;   // exceeds the longest receiver hold-off
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [2:0] st;
    } t_deframe_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_buffer = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_is_last;
    logic [2:0] o_status;

    t_rx_item        pending_bytes[$];
    t_deframe_result expected_results[$];
    t_rx_item        next_item;
    t_deframe_result seen_result;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_cnt = 0;
    int idle_cycles = 0;
    int mismatches  = 0;

    // parser state of the predictor
    wsfd_pkg::t_phase  ph;
    logic [2:0]        seen_cnt;
    logic [3:0]        opc;
    logic              masked;
    logic [15:0]       plen;
    logic [15:0]       pidx;
    logic [31:0]       key;
    wsfd_pkg::t_status err_st;

    websocket_frame_deframer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_is_last      (o_is_last),
        .o_status       (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void reset_parser();
        ph       = wsfd_pkg::PH_OP;
        seen_cnt = 3'd0;
        opc      = 4'h0;
        masked   = 1'b0;
        plen     = 16'h0000;
        pidx     = 16'h0000;
        key      = 32'h0000_0000;
        err_st   = wsfd_pkg::ST_OK;
    endfunction

    function automatic void start_body();
        pidx = 16'h0000;
        if (masked)
            ph = wsfd_pkg::PH_KEY;
        else
            ph = (plen == 16'h0000) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAY;
    endfunction

    // Work out the results one accepted byte gives and queue them.
    function automatic void deframe_byte(input logic [7:0] b, input logic eob);
        t_deframe_result   r;
        wsfd_pkg::t_status fin;
        if (seen_cnt < wsfd_pkg::MIN_BYTES)
            seen_cnt = seen_cnt + 3'd1;
        case (ph)
            wsfd_pkg::PH_OP: begin
                opc = b[3:0];
                if (opc == wsfd_pkg::OPCODE_CLOSE) begin
                    err_st = wsfd_pkg::ST_CLOSE;
                    ph     = wsfd_pkg::PH_DONE;
                end else if (opc != wsfd_pkg::OPCODE_TEXT) begin
                    err_st = wsfd_pkg::ST_TEXT;
                    ph     = wsfd_pkg::PH_DONE;
                end else begin
                    ph = wsfd_pkg::PH_LEN;
                end
            end
            wsfd_pkg::PH_LEN: begin
                masked = b[7];
                plen   = {9'd0, b[6:0]};
                if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
                    ph = wsfd_pkg::PH_EXT_HI;
                end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
                    err_st = wsfd_pkg::ST_LEN64;
                    ph     = wsfd_pkg::PH_DONE;
                end else begin
                    start_body();
                end
            end
            wsfd_pkg::PH_EXT_HI: begin
                plen = {b, 8'h00};
                ph   = wsfd_pkg::PH_EXT_LO;
            end
            wsfd_pkg::PH_EXT_LO: begin
                plen[7:0] = b;
                start_body();
            end
            wsfd_pkg::PH_KEY: begin
                key[8 * pidx[1:0] +: 8] = b;
                pidx = pidx + 16'd1;
                if (pidx >= 16'd4) begin
                    pidx = 16'h0000;
                    ph   = (plen == 16'h0000) ? wsfd_pkg::PH_DONE : wsfd_pkg::PH_PAY;
                end
            end
            wsfd_pkg::PH_PAY: begin
                r.data  = masked ? (b ^ key[8 * pidx[1:0] +: 8]) : b;
                r.valid = 1'b1;
                r.last  = 1'b0;
                r.st    = wsfd_pkg::ST_OK;
                expected_results.insert(expected_results.size(), r);
                pidx = pidx + 16'd1;
                if (pidx >= plen)
                    ph = wsfd_pkg::PH_DONE;
            end
            default: ;
        endcase
        if (eob) begin
            if (seen_cnt < wsfd_pkg::MIN_BYTES)
                fin = wsfd_pkg::ST_SHORT;
            else if (err_st != wsfd_pkg::ST_OK)
                fin = err_st;
            else if (ph != wsfd_pkg::PH_DONE)
                fin = wsfd_pkg::ST_TRUNC;
            else
                fin = wsfd_pkg::ST_OK;
            r.data  = 8'h00;
            r.valid = 1'b0;
            r.last  = 1'b1;
            r.st    = fin;
            expected_results.insert(expected_results.size(), r);
            reset_parser();
        end
    endfunction

    // Driver: keeps push up while full, otherwise offers the next byte or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            reset_parser();
        end else begin
            if (push && !full)
                deframe_byte(i_data_byte, i_end_of_buffer);
            if (!push || !full) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    next_item = pending_bytes.pop_front();
                    push            <= 1'b1;
                    i_data_byte     <= next_item.data;
                    i_end_of_buffer <= next_item.eob;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each popped result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: out_byte %0h byte_valid %0b is_last %0b status %0d",
                           o_out_byte, o_byte_valid, o_is_last, o_status);
                    mismatches++;
                end else begin
                    seen_result = expected_results.pop_front();
                    if (o_out_byte !== seen_result.data) begin
                        $error("out_byte: expected %0h, got %0h", seen_result.data, o_out_byte);
                        mismatches++;
                    end
                    if (o_byte_valid !== seen_result.valid) begin
                        $error("byte_valid: expected %0b, got %0b",
                               seen_result.valid, o_byte_valid);
                        mismatches++;
                    end
                    if (o_is_last !== seen_result.last) begin
                        $error("is_last: expected %0b, got %0b", seen_result.last, o_is_last);
                        mismatches++;
                    end
                    if (o_status !== seen_result.st) begin
                        $error("status: expected %0d, got %0d", seen_result.st, o_status);
                        mismatches++;
                    end
                end
            end
            pop <= (rx_hold_cnt == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge i_clk) begin
        if (rx_hold_cnt != 0)
            rx_hold_cnt <= rx_hold_cnt - 1;
    end

    // Watchdog: only counts while work is outstanding.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) ||
                (pending_bytes.size() == 0 && !push && expected_results.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[websocket_frame_deframer_top] ERROR");
                $finish;
            end
        end
    end

    task automatic queue_buffer(input logic [7:0] frm[$]);
        t_rx_item it;
        foreach (frm[k]) begin
            it.data = frm[k];
            it.eob  = (k == frm.size() - 1);
            pending_bytes.insert(pending_bytes.size(), it);
        end
    endtask

    // One random receive buffer; mostly well-formed text frames.
    task automatic gen_buffer(output int n);
        logic [7:0] frm[$];
        logic [7:0] op;
        logic       msk;
        int         kind;
        int         sel;
        int         len;
        int         cut;
        kind = $urandom_range(99);
        op   = 8'($urandom);
        if (kind < 70) begin
            op[3:0] = wsfd_pkg::OPCODE_TEXT;
            frm.insert(frm.size(), op);
            msk = 1'($urandom_range(1));
            sel = $urandom_range(9);
            if (sel < 7) begin
                len = $urandom_range(20);
                frm.insert(frm.size(), {msk, len[6:0]});
            end else begin
                len = (sel < 9) ? $urandom_range(40) : $urandom_range(65535);
                frm.insert(frm.size(), {msk, wsfd_pkg::LEN_EXT16});
                frm.insert(frm.size(), len[15:8]);
                frm.insert(frm.size(), len[7:0]);
            end
            if (msk)
                repeat (4) frm.insert(frm.size(), 8'($urandom));
            // huge lengths end up truncated
            repeat ((len > 60) ? $urandom_range(30) : len)
                frm.insert(frm.size(), 8'($urandom));
            if ($urandom_range(6) == 0)
                repeat ($urandom_range(5, 1)) frm.insert(frm.size(), 8'($urandom));
            if ($urandom_range(7) == 0) begin
                cut = $urandom_range(frm.size(), 1);
                while (frm.size() > cut) void'(frm.pop_back());
            end
        end else if (kind < 76) begin
            repeat ($urandom_range(10, 1)) frm.insert(frm.size(), 8'($urandom));
        end else if (kind < 82) begin
            op[3:0] = wsfd_pkg::OPCODE_CLOSE;
            frm.insert(frm.size(), op);
            repeat ($urandom_range(8)) frm.insert(frm.size(), 8'($urandom));
        end else if (kind < 88) begin
            while (op[3:0] == wsfd_pkg::OPCODE_TEXT || op[3:0] == wsfd_pkg::OPCODE_CLOSE)
                op = 8'($urandom);
            frm.insert(frm.size(), op);
            repeat ($urandom_range(8)) frm.insert(frm.size(), 8'($urandom));
        end else begin
            op[3:0] = wsfd_pkg::OPCODE_TEXT;
            frm.insert(frm.size(), op);
            frm.insert(frm.size(), {1'($urandom_range(1)), wsfd_pkg::LEN_EXT64});
            repeat ($urandom_range(8)) frm.insert(frm.size(), 8'($urandom));
        end
        queue_buffer(frm);
        n = frm.size();
    endtask

    // Waits until every queued byte is sent and every expected result has been popped.
    task automatic drain();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || push || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int nbytes);
        int total;
        int n;
        @(negedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        total = 0;
        while (total < nbytes) begin
            gen_buffer(n);
            total += n;
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short buffer, close, non-text, 64-bit length, empty payload + trailer
        @(negedge i_clk);
        queue_buffer('{8'h81});
        queue_buffer('{8'h88, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78});
        queue_buffer('{8'h02, 8'h05, 8'hFF, 8'h00, 8'hAA, 8'h55});
        queue_buffer('{8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        queue_buffer('{8'h81, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h80});
        drain();

        run_phase(0, 0, 500);
        run_phase(86, 0, 450);
        run_phase(0, 86, 450);
        run_phase(36, 36, 450);

        // receiver holds off while the sender keeps offering, so full must rise
        @(negedge i_clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cnt = 400;
        run_phase(0, 0, 100);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[websocket_frame_deframer_top] OK");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("[websocket_frame_deframer_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_queue.sv
rtl/wsfd_front.sv
rtl/wsfd_back.sv
rtl/websocket_frame_deframer_top.sv
rtl/wsfd_checker.sv
tb/sv/tb.sv
